>>> rtl/core/xxh64_pkg.sv
// xxh64_pkg: constants, command and status types, rotate helper for the xxh64 digest
// used by xxh64_ctrl, xxh64_dp and xxhash64_stream_digest; no dependencies
package xxh64_pkg;

    localparam logic [63:0] PRIME1 = 64'h9E3779B185EBCA87;
    localparam logic [63:0] PRIME2 = 64'hC2B2AE3D27D4EB4F;
    localparam logic [63:0] PRIME3 = 64'h165667B19E3779F9;
    localparam logic [63:0] PRIME4 = 64'h85EBCA77C2B2AE63;
    localparam logic [63:0] PRIME5 = 64'h27D4EB2F165667C5;

    localparam int LANES = 4;
    localparam int STRIPE_BYTES = 32;

    localparam logic [63:0] ACC0_INIT = PRIME1 + PRIME2;
    localparam logic [63:0] ACC1_INIT = PRIME2;
    localparam logic [63:0] ACC2_INIT = 64'd0;
    localparam logic [63:0] ACC3_INIT = 64'd0 - PRIME1;

    typedef enum logic [4:0] {
        OP_NONE       = 5'd0,
        OP_ABSORB     = 5'd1,
        OP_LD_LANE    = 5'd2,
        OP_LD_W8      = 5'd3,
        OP_LD_W4      = 5'd4,
        OP_LD_B       = 5'd5,
        OP_LD_ACC     = 5'd6,
        OP_MUL        = 5'd7,
        OP_MID_ACC    = 5'd8,
        OP_MID_ZERO   = 5'd9,
        OP_ACC_WR     = 5'd10,
        OP_INIT_LONG  = 5'd11,
        OP_INIT_SHORT = 5'd12,
        OP_ADD_LEN    = 5'd13,
        OP_XOR_LD     = 5'd14,
        OP_XOR_ROT    = 5'd15,
        OP_P_ADD      = 5'd16,
        OP_H_SHR      = 5'd17,
        OP_P_SHR      = 5'd18,
        OP_FINAL      = 5'd19
    } op_t;

    typedef enum logic [2:0] {
        K_ZERO = 3'd0,
        K_P1   = 3'd1,
        K_P2   = 3'd2,
        K_P3   = 3'd3,
        K_P4   = 3'd4,
        K_P5   = 3'd5
    } kc_t;

    typedef struct packed {
        op_t        op;
        kc_t        kc;
        logic [1:0] step;
        logic [5:0] amt;
        logic [3:0] adv;
    } cmd_t;

    typedef struct packed {
        logic [4:0] fill;
        logic [4:0] pos;
        logic [1:0] lane;
        logic       long_msg;
    } stat_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] w;
        begin
            w = {x, x} << r;
            return w[127:64];
        end
    endfunction

endpackage

>>> rtl/core/xxh64_dp.sv
// xxh64_dp: stripe buffer, lane accumulators, length, hash and shared multiplier
// depends on xxh64_pkg; driven by cmd_t from xxh64_ctrl
module xxh64_dp
    import xxh64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [7:0]  data_byte,
    output stat_t       stat,
    output logic [63:0] digest
);

    logic [8*STRIPE_BYTES-1:0] buf_reg;
    logic [63:0]  acc_reg [LANES];
    logic [4:0]   fill_reg;
    logic [63:0]  len_reg;
    logic [4:0]   pos_reg;
    logic [1:0]   lane_reg;
    logic [63:0]  h_reg;
    logic [63:0]  ma_reg;
    logic [63:0]  p_reg;
    logic [63:0]  digest_reg;

    logic [63:0]  kval;
    logic [31:0]  mx;
    logic [31:0]  my;
    logic [63:0]  prod;
    logic [8*STRIPE_BYTES-1:0] tail_win;
    logic [8*STRIPE_BYTES-1:0] lane_win;
    logic [63:0]  hx;
    logic [63:0]  hs;
    logic [63:0]  ps;
    logic [63:0]  mid_sum;

    always_comb
    begin
        case (cmd.kc)
            K_P1:    kval = PRIME1;
            K_P2:    kval = PRIME2;
            K_P3:    kval = PRIME3;
            K_P4:    kval = PRIME4;
            K_P5:    kval = PRIME5;
            default: kval = 64'd0;
        endcase
    end

    // one 32x32 product per cycle: low*low, then the two cross terms
    always_comb
    begin
        case (cmd.step)
            2'd0:    begin mx = ma_reg[31:0];  my = kval[31:0];  end
            2'd1:    begin mx = ma_reg[31:0];  my = kval[63:32]; end
            default: begin mx = ma_reg[63:32]; my = kval[31:0];  end
        endcase
    end

    assign prod     = mx * my;
    assign tail_win = buf_reg >> {pos_reg, 3'b000};
    assign lane_win = buf_reg >> {lane_reg, 6'b000000};
    assign hx       = h_reg ^ p_reg;
    assign hs       = h_reg ^ (h_reg >> cmd.amt);
    assign ps       = p_reg ^ (p_reg >> cmd.amt);
    assign mid_sum  = acc_reg[lane_reg] + p_reg;

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_ABSORB:     buf_reg[{fill_reg, 3'b000} +: 8] <= data_byte;
            default:       ;
        endcase
        case (cmd.op)
            OP_LD_LANE:    ma_reg <= lane_win[63:0];
            OP_LD_W8:      ma_reg <= tail_win[63:0];
            OP_LD_W4:      ma_reg <= {32'd0, tail_win[31:0]};
            OP_LD_B:       ma_reg <= {56'd0, tail_win[7:0]};
            OP_LD_ACC:     ma_reg <= acc_reg[lane_reg];
            OP_MID_ACC:    ma_reg <= rotl64(mid_sum, 6'd31);
            OP_MID_ZERO:   ma_reg <= rotl64(p_reg, 6'd31);
            OP_XOR_LD:     ma_reg <= hx;
            OP_XOR_ROT:    ma_reg <= rotl64(hx, cmd.amt);
            OP_H_SHR:      ma_reg <= hs;
            OP_P_SHR:      ma_reg <= ps;
            default:       ;
        endcase
        case (cmd.op)
            OP_MUL:
            begin
                if (cmd.step == 2'd0)
                    p_reg <= prod;
                else
                    p_reg <= p_reg + {prod[31:0], 32'd0};
            end
            default:       ;
        endcase
        case (cmd.op)
            OP_INIT_LONG:  h_reg <= rotl64(acc_reg[0], 6'd1) + rotl64(acc_reg[1], 6'd7)
                                  + rotl64(acc_reg[2], 6'd12) + rotl64(acc_reg[3], 6'd18);
            OP_INIT_SHORT: h_reg <= PRIME5;
            OP_ADD_LEN:    h_reg <= h_reg + len_reg;
            OP_XOR_LD:     h_reg <= hx;
            OP_XOR_ROT:    h_reg <= hx;
            OP_P_ADD:      h_reg <= p_reg + kval;
            OP_H_SHR:      h_reg <= hs;
            OP_P_SHR:      h_reg <= ps;
            default:       ;
        endcase
        if (cmd.op == OP_FINAL)
            digest_reg <= p_reg ^ (p_reg >> 32);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg[0] <= ACC0_INIT;
            acc_reg[1] <= ACC1_INIT;
            acc_reg[2] <= ACC2_INIT;
            acc_reg[3] <= ACC3_INIT;
            fill_reg   <= '0;
            len_reg    <= '0;
            pos_reg    <= '0;
            lane_reg   <= '0;
        end
        else
        begin
            case (cmd.op)
                OP_ABSORB:
                begin
                    fill_reg <= fill_reg + 5'd1;
                    len_reg  <= len_reg + 64'd1;
                end
                OP_ACC_WR:
                begin
                    acc_reg[lane_reg] <= p_reg;
                    lane_reg          <= lane_reg + 2'd1;
                end
                OP_P_ADD:
                begin
                    lane_reg <= lane_reg + 2'd1;
                    pos_reg  <= pos_reg + {1'b0, cmd.adv};
                end
                OP_FINAL:
                begin
                    acc_reg[0] <= ACC0_INIT;
                    acc_reg[1] <= ACC1_INIT;
                    acc_reg[2] <= ACC2_INIT;
                    acc_reg[3] <= ACC3_INIT;
                    fill_reg   <= '0;
                    len_reg    <= '0;
                    pos_reg    <= '0;
                    lane_reg   <= '0;
                end
                default: ;
            endcase
        end
    end

    assign stat.fill     = fill_reg;
    assign stat.pos      = pos_reg;
    assign stat.lane     = lane_reg;
    assign stat.long_msg = |len_reg[63:5];
    assign digest        = digest_reg;

endmodule

>>> rtl/core/xxh64_ctrl.sv
// xxh64_ctrl: sequencer for absorb, stripe rounds, merge, tail folding and avalanche
// depends on xxh64_pkg; issues cmd_t to xxh64_dp and owns both handshakes
module xxh64_ctrl
    import xxh64_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  byte_valid,
    input  logic  last,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [37:0] {
        S_IDLE   = 38'd1 << 0,
        S_LD     = 38'd1 << 1,
        S_M1     = 38'd1 << 2,
        S_MID    = 38'd1 << 3,
        S_M2     = 38'd1 << 4,
        S_WR     = 38'd1 << 5,
        F_INIT   = 38'd1 << 6,
        F_LD     = 38'd1 << 7,
        F_M1     = 38'd1 << 8,
        F_MID    = 38'd1 << 9,
        F_M2     = 38'd1 << 10,
        F_X      = 38'd1 << 11,
        F_M3     = 38'd1 << 12,
        F_ADD    = 38'd1 << 13,
        F_LEN    = 38'd1 << 14,
        F_SEL    = 38'd1 << 15,
        T8_LD    = 38'd1 << 16,
        T8_M1    = 38'd1 << 17,
        T8_MID   = 38'd1 << 18,
        T8_M2    = 38'd1 << 19,
        T8_X     = 38'd1 << 20,
        T8_M3    = 38'd1 << 21,
        T8_ADD   = 38'd1 << 22,
        T4_LD    = 38'd1 << 23,
        T4_M1    = 38'd1 << 24,
        T4_X     = 38'd1 << 25,
        T4_M2    = 38'd1 << 26,
        T4_ADD   = 38'd1 << 27,
        T1_LD    = 38'd1 << 28,
        T1_M1    = 38'd1 << 29,
        T1_X     = 38'd1 << 30,
        T1_M2    = 38'd1 << 31,
        T1_ADD   = 38'd1 << 32,
        A_X1     = 38'd1 << 33,
        A_M1     = 38'd1 << 34,
        A_X2     = 38'd1 << 35,
        A_M2     = 38'd1 << 36,
        A_DONE   = 38'd1 << 37
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] mstep_reg, mstep_next;
    logic       pend_reg, pend_next;
    logic       ovalid_reg, ovalid_next;
    logic       is_mul;
    logic       mul_done;
    logic       lane_last;
    logic [5:0] fill6;
    logic [5:0] pos6;

    assign mul_done  = (mstep_reg == 2'd2);
    assign lane_last = (stat.lane == 2'd3);
    assign fill6     = {1'b0, stat.fill};
    assign pos6      = {1'b0, stat.pos};
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ovalid_reg;

    always_comb
    begin
        state_next  = state_reg;
        pend_next   = pend_reg;
        ovalid_next = ovalid_reg && !out_ready;
        is_mul      = 1'b0;
        cmd         = '{op: OP_NONE, kc: K_ZERO, step: mstep_reg, amt: 6'd0, adv: 4'd0};
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pend_next = last;
                    if (byte_valid)
                    begin
                        cmd.op = OP_ABSORB;
                        if (stat.fill == 5'd31)
                            state_next = S_LD;
                        else if (last)
                            state_next = F_INIT;
                    end
                    else if (last)
                        state_next = F_INIT;
                end
            end
            S_LD:   begin cmd.op = OP_LD_LANE; state_next = S_M1; end
            S_M1:   begin is_mul = 1'b1; cmd.kc = K_P2; if (mul_done) state_next = S_MID; end
            S_MID:  begin cmd.op = OP_MID_ACC; state_next = S_M2; end
            S_M2:   begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = S_WR; end
            S_WR:
            begin
                cmd.op = OP_ACC_WR;
                if (!lane_last)
                    state_next = S_LD;
                else if (pend_reg)
                    state_next = F_INIT;
                else
                    state_next = S_IDLE;
            end
            F_INIT:
            begin
                if (stat.long_msg)
                begin
                    cmd.op     = OP_INIT_LONG;
                    state_next = F_LD;
                end
                else
                begin
                    cmd.op     = OP_INIT_SHORT;
                    state_next = F_LEN;
                end
            end
            F_LD:   begin cmd.op = OP_LD_ACC; state_next = F_M1; end
            F_M1:   begin is_mul = 1'b1; cmd.kc = K_P2; if (mul_done) state_next = F_MID; end
            F_MID:  begin cmd.op = OP_MID_ZERO; state_next = F_M2; end
            F_M2:   begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = F_X; end
            F_X:    begin cmd.op = OP_XOR_LD; state_next = F_M3; end
            F_M3:   begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = F_ADD; end
            F_ADD:
            begin
                cmd.op     = OP_P_ADD;
                cmd.kc     = K_P4;
                state_next = lane_last ? F_LEN : F_LD;
            end
            F_LEN:  begin cmd.op = OP_ADD_LEN; state_next = F_SEL; end
            F_SEL:
            begin
                if (pos6 + 6'd8 <= fill6)
                    state_next = T8_LD;
                else if (pos6 + 6'd4 <= fill6)
                    state_next = T4_LD;
                else if (pos6 < fill6)
                    state_next = T1_LD;
                else
                    state_next = A_X1;
            end
            T8_LD:  begin cmd.op = OP_LD_W8; state_next = T8_M1; end
            T8_M1:  begin is_mul = 1'b1; cmd.kc = K_P2; if (mul_done) state_next = T8_MID; end
            T8_MID: begin cmd.op = OP_MID_ZERO; state_next = T8_M2; end
            T8_M2:  begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = T8_X; end
            T8_X:   begin cmd.op = OP_XOR_ROT; cmd.amt = 6'd27; state_next = T8_M3; end
            T8_M3:  begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = T8_ADD; end
            T8_ADD:
            begin
                cmd.op     = OP_P_ADD;
                cmd.kc     = K_P4;
                cmd.adv    = 4'd8;
                state_next = F_SEL;
            end
            T4_LD:  begin cmd.op = OP_LD_W4; state_next = T4_M1; end
            T4_M1:  begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = T4_X; end
            T4_X:   begin cmd.op = OP_XOR_ROT; cmd.amt = 6'd23; state_next = T4_M2; end
            T4_M2:  begin is_mul = 1'b1; cmd.kc = K_P2; if (mul_done) state_next = T4_ADD; end
            T4_ADD:
            begin
                cmd.op     = OP_P_ADD;
                cmd.kc     = K_P3;
                cmd.adv    = 4'd4;
                state_next = F_SEL;
            end
            T1_LD:  begin cmd.op = OP_LD_B; state_next = T1_M1; end
            T1_M1:  begin is_mul = 1'b1; cmd.kc = K_P5; if (mul_done) state_next = T1_X; end
            T1_X:   begin cmd.op = OP_XOR_ROT; cmd.amt = 6'd11; state_next = T1_M2; end
            T1_M2:  begin is_mul = 1'b1; cmd.kc = K_P1; if (mul_done) state_next = T1_ADD; end
            T1_ADD:
            begin
                cmd.op     = OP_P_ADD;
                cmd.kc     = K_ZERO;
                cmd.adv    = 4'd1;
                state_next = F_SEL;
            end
            A_X1:   begin cmd.op = OP_H_SHR; cmd.amt = 6'd33; state_next = A_M1; end
            A_M1:   begin is_mul = 1'b1; cmd.kc = K_P2; if (mul_done) state_next = A_X2; end
            A_X2:   begin cmd.op = OP_P_SHR; cmd.amt = 6'd29; state_next = A_M2; end
            A_M2:   begin is_mul = 1'b1; cmd.kc = K_P3; if (mul_done) state_next = A_DONE; end
            A_DONE:
            begin
                // wait until the output register is free
                if (!ovalid_reg || out_ready)
                begin
                    cmd.op      = OP_FINAL;
                    ovalid_next = 1'b1;
                    pend_next   = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        if (is_mul)
            cmd.op = OP_MUL;
        mstep_next = (is_mul && !mul_done) ? mstep_reg + 2'd1 : 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            mstep_reg  <= '0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mstep_reg  <= mstep_next;
            pend_reg   <= pend_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

>>> rtl/core/xxhash64_stream_digest.sv
// xxhash64_stream_digest: top level of the seed-zero xxh64 stream digest
// depends on xxh64_pkg, xxh64_ctrl and xxh64_dp
//
// input channel: in_valid/in_ready carry one word per handshake: data_byte,
// byte_valid (byte belongs to the message) and last (close the message).
// output channel: out_valid/out_ready carry the 64-bit digest, one per message.
// a word without a byte and without last is accepted and does nothing.
// a plain byte leaves in_ready high for the next word. the byte that fills a 32-byte stripe
// starts the four lane rounds, each two 64-bit multiplies done as
// three 32x32 partial products on the single shared multiplier.
// a closing word picks the start value, merges the lanes (long messages
// only), adds the length, folds each 8-byte tail word, 4-byte word and tail
// byte and runs the avalanche; in_ready is low for all of that.
// reset restores the initial accumulators, zero length and an empty stripe.
// when the receiver stalls, the digest holds in its output register and new
// bytes are still taken; the next closing word waits until the digest drains.
module xxhash64_stream_digest
    import xxh64_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] digest
);

    cmd_t  cmd;
    stat_t stat;

    xxh64_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .byte_valid (byte_valid),
        .last       (last),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    xxh64_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .data_byte (data_byte),
        .stat      (stat),
        .digest    (digest)
    );

endmodule
